// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the box wall bounce resolver.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define BWBR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BWBR_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/bwbr_pkg.sv -----
// Shared widths, divider cell record, register indexes and wall tables
// of the box wall bounce resolver. Depends on nothing.
package bwbr_pkg;

    localparam int PW  = 36;        // internal position width
    localparam int VW  = 34;        // internal velocity and ray width
    localparam int RW  = VW + 1;    // divider partial remainder width
    localparam int QW  = 32;        // hit time quotient width, Q0.32
    localparam int MAW = VW + 1;    // multiplier operand a, signed
    localparam int MBW = 33;        // multiplier operand b, unsigned
    localparam int MPW = MAW + MBW + 1;

    localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
    localparam logic [2:0] REG_REST_NORMAL = 3'd2;
    localparam logic [2:0] REG_REST_TANG   = 3'd3;
    localparam logic [2:0] REG_TIME_STEP   = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // One wall test travelling down the divider row.
    typedef struct packed {
        logic          live;
        logic          hit;
        logic [2:0]    wall;
        logic [RW-1:0] rem;
        logic [VW-1:0] dvs;
        logic [QW-1:0] quo;
    } bwbr_div_t;

    // Walls in priority order: floor, +x, -x, +z, -z, lid.
    function automatic logic [1:0] wall_axis(input logic [2:0] w);
        logic [1:0] a;
        case (w)
            3'd0:    a = AXIS_Y;
            3'd1:    a = AXIS_X;
            3'd2:    a = AXIS_X;
            3'd3:    a = AXIS_Z;
            3'd4:    a = AXIS_Z;
            3'd5:    a = AXIS_Y;
            default: a = AXIS_X;
        endcase
        return a;
    endfunction

    // True where the wall sits on the negative side, so the ray hits it
    // moving in the negative direction.
    function automatic logic wall_low(input logic [2:0] w);
        logic s;
        case (w)
            3'd0:    s = 1'b1;
            3'd2:    s = 1'b1;
            3'd4:    s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic signed [31:0] sat_q16(input logic signed [PW-1:0] x);
        logic signed [31:0] y;
        if (x > $signed({{(PW-32){1'b0}}, 32'h7FFF_FFFF})) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < $signed({{(PW-32){1'b1}}, 32'h8000_0000})) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// ----- src/box_wall_bounce_resolver.sv -----
// Top level of the box wall bounce resolver: sequencer, particle state,
// shared multiplier and output register. Depends on bwbr_pkg,
// bwbr_div_chain and assert_macros.svh.
//
//   channel   | ports                        | direction
//   ----------+------------------------------+----------
//   input     | s_valid s_ready s_pos_* s_vel_* | in
//   result    | m_valid m_ready m_new_* m_bounce_limit_hit | out
//   config    | cfg_wr_en cfg_index cfg_wr_data | in
//
// One particle is resolved at a time. Each particle first loads its ray on
// the shared multiplier. Each wall search then issues six wall tests into
// the divider row, collects their hit times as they come out and decides.
// Each bounce advances the particle to the hit on the shared multiplier and
// then scales ray and velocity by restitution on it. A particle stops when
// no wall is hit or when the bounce limit is reached. Reset is synchronous
// and active low; it clears control state and loads the configuration
// defaults, not the datapath registers. A stalled result sits in the output
// register; the next particle is taken while it waits, and the finished
// particle after it waits until the register is free.
module box_wall_bounce_resolver #(
    parameter int DIMENSIONS  = 3,
    parameter int MAX_BOUNCES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_vel_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_pos_z,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic signed [31:0] m_new_vel_z,
    output logic               m_bounce_limit_hit
);

    `include "assert_macros.svh"

    localparam int PW  = bwbr_pkg::PW;
    localparam int VW  = bwbr_pkg::VW;
    localparam int BCW = $clog2(MAX_BOUNCES + 1);

    localparam logic [2:0] CNT_AXES   = 3'd3;
    localparam logic [2:0] WALL_LAST  = 3'd5;
    localparam logic [2:0] SCALE_LAST = 3'd6;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RAY    = 8'b0000_0010,
        ST_ISSUE  = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_ADV    = 8'b0010_0000,
        ST_SCALE  = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    // Configuration registers.
    logic [30:0] half_width_reg;
    logic [30:0] half_height_reg;
    logic [16:0] rest_normal_reg;
    logic [16:0] rest_tang_reg;
    logic [15:0] time_step_reg;

    // Sequencer.
    state_t           state_reg, state_next;
    logic [2:0]       cnt_reg;
    logic [BCW-1:0]   bounce_cnt_reg;
    logic             limit_reg;

    // Particle state: position, velocity and remaining ray per axis.
    logic signed [PW-1:0] p_reg [3];
    logic signed [VW-1:0] v_reg [3];
    logic signed [VW-1:0] r_reg [3];

    // Best hit of the current search.
    logic [32:0] t_best_reg;
    logic [2:0]  hit_wall_reg;
    logic        found_reg;

    // Shared multiplier.
    logic signed [bwbr_pkg::MAW-1:0] mul_a;
    logic        [bwbr_pkg::MBW-1:0] mul_b;
    logic signed [bwbr_pkg::MPW-1:0] mul_prod_reg;
    logic signed [VW-1:0]            prod_sh16;
    logic signed [VW-1:0]            prod_sh32;

    logic [2:0]  wbc;
    logic [1:0]  iss_axis;
    logic [1:0]  wb_axis;
    logic [16:0] rn;
    logic [16:0] rt;
    logic        scale_normal;
    logic signed [VW-1:0] scale_x;

    // Wall test feed.
    logic [1:0]             w_axis;
    logic                   w_low;
    logic [30:0]            w_half;
    logic signed [PW-1:0]   w_p;
    logic signed [VW-1:0]   w_r;
    logic signed [PW:0]     w_dist;
    logic [VW-1:0]          w_spd;
    logic                   w_toward;
    bwbr_pkg::bwbr_div_t    div_in;
    bwbr_pkg::bwbr_div_t    div_out;

    logic s_fire;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    // Restitution above one saturates to one.
    assign rn = (rest_normal_reg > 17'd65536) ? 17'd65536 : rest_normal_reg;
    assign rt = (rest_tang_reg > 17'd65536) ? 17'd65536 : rest_tang_reg;

    // Element index handled this cycle, and the one written back from the
    // multiplier register, which was handled in the cycle before.
    assign wbc      = cnt_reg - 3'd1;
    assign iss_axis = (cnt_reg >= CNT_AXES) ? 2'(cnt_reg - CNT_AXES) : cnt_reg[1:0];
    assign wb_axis  = (wbc >= CNT_AXES) ? 2'(wbc - CNT_AXES) : wbc[1:0];

    always_comb begin
        scale_x      = (cnt_reg < CNT_AXES) ? r_reg[iss_axis] : v_reg[iss_axis];
        scale_normal = (iss_axis == bwbr_pkg::wall_axis(hit_wall_reg));
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ST_RAY: begin
                mul_a = {v_reg[iss_axis][VW-1], v_reg[iss_axis]};
                mul_b = {17'd0, time_step_reg};
            end
            ST_ADV: begin
                mul_a = {r_reg[iss_axis][VW-1], r_reg[iss_axis]};
                mul_b = t_best_reg;
            end
            ST_SCALE: begin
                // The normal part is reversed and scaled by its own factor.
                if (scale_normal) begin
                    mul_a = -{scale_x[VW-1], scale_x};
                    mul_b = {16'd0, rn};
                end else begin
                    mul_a = {scale_x[VW-1], scale_x};
                    mul_b = {16'd0, rt};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Arithmetic shifts of the product floor toward minus infinity.
    assign prod_sh16 = mul_prod_reg[VW+15:16];
    assign prod_sh32 = mul_prod_reg[VW+31:32];

    // Wall test for the wall numbered by the counter. A wall counts when the
    // ray moves strictly toward it, the particle is on the inner side, and
    // the wall is reached within the remaining ray.
    always_comb begin
        w_axis   = bwbr_pkg::wall_axis(cnt_reg);
        w_low    = bwbr_pkg::wall_low(cnt_reg);
        w_half   = (w_axis == bwbr_pkg::AXIS_Y) ? half_height_reg : half_width_reg;
        w_p      = p_reg[w_axis];
        w_r      = r_reg[w_axis];
        if (w_low) begin
            w_toward = w_r[VW-1];
            w_dist   = {w_p[PW-1], w_p} + $signed({{(PW+1-31){1'b0}}, w_half});
            w_spd    = -w_r;
        end else begin
            w_toward = !w_r[VW-1] && (w_r != '0);
            w_dist   = $signed({{(PW+1-31){1'b0}}, w_half}) - {w_p[PW-1], w_p};
            w_spd    = w_r;
        end
        div_in.live = (state_reg == ST_ISSUE);
        div_in.hit  = w_toward && !w_dist[PW] &&
                      (w_dist < $signed({{(PW+1-VW){1'b0}}, w_spd}));
        div_in.wall = cnt_reg;
        div_in.rem  = w_dist[bwbr_pkg::RW-1:0];
        div_in.dvs  = w_spd;
        div_in.quo  = '0;
    end

    bwbr_div_chain u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_in  (div_in),
        .div_out (div_out)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_RAY;
            end
            ST_RAY: begin
                if (cnt_reg == CNT_AXES) state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (cnt_reg == WALL_LAST) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (div_out.live && div_out.wall == WALL_LAST) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = found_reg ? ST_ADV : ST_FIN;
            end
            ST_ADV: begin
                if (cnt_reg == CNT_AXES) begin
                    state_next = (bounce_cnt_reg >= BCW'(MAX_BOUNCES)) ? ST_FIN : ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (cnt_reg == SCALE_LAST) state_next = ST_ISSUE;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes are to arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= 31'd65536;
            half_height_reg <= 31'd32768;
            rest_normal_reg <= 17'd62259;
            rest_tang_reg   <= 17'd65536;
            time_step_reg   <= 16'd1092;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bwbr_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_wr_data;
                bwbr_pkg::REG_HALF_HEIGHT: half_height_reg <= cfg_wr_data;
                bwbr_pkg::REG_REST_NORMAL: rest_normal_reg <= cfg_wr_data[16:0];
                bwbr_pkg::REG_REST_TANG:   rest_tang_reg   <= cfg_wr_data[16:0];
                bwbr_pkg::REG_TIME_STEP:   time_step_reg   <= cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            bounce_cnt_reg <= '0;
            limit_reg      <= 1'b0;
            found_reg      <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;
            if (s_fire) begin
                bounce_cnt_reg <= '0;
                limit_reg      <= 1'b0;
            end
            if (state_reg == ST_ISSUE && cnt_reg == 3'd0) begin
                found_reg <= 1'b0;
            end
            if (state_reg == ST_DRAIN && div_out.live && div_out.hit &&
                {1'b0, div_out.quo} <= t_best_reg) begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_ADV && cnt_reg == CNT_AXES &&
                bounce_cnt_reg >= BCW'(MAX_BOUNCES)) begin
                limit_reg <= 1'b1;
            end
            if (state_reg == ST_SCALE && cnt_reg == SCALE_LAST) begin
                bounce_cnt_reg <= bounce_cnt_reg + BCW'(1);
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        mul_prod_reg <= mul_a * $signed({1'b0, mul_b});

        if (s_fire) begin
            p_reg[0] <= {{(PW-32){s_pos_x[31]}}, s_pos_x};
            p_reg[1] <= {{(PW-32){s_pos_y[31]}}, s_pos_y};
            p_reg[2] <= {{(PW-32){s_pos_z[31]}}, s_pos_z};
            v_reg[0] <= {{(VW-32){s_vel_x[31]}}, s_vel_x};
            v_reg[1] <= {{(VW-32){s_vel_y[31]}}, s_vel_y};
            v_reg[2] <= {{(VW-32){s_vel_z[31]}}, s_vel_z};
        end

        if (state_reg == ST_RAY && cnt_reg != 3'd0) begin
            r_reg[wb_axis] <= prod_sh16;
        end

        if (state_reg == ST_ISSUE && cnt_reg == 3'd0) begin
            t_best_reg <= 33'h1_0000_0000;
        end

        // Equal times go to the later wall in priority order.
        if (state_reg == ST_DRAIN && div_out.live && div_out.hit &&
            {1'b0, div_out.quo} <= t_best_reg) begin
            t_best_reg   <= {1'b0, div_out.quo};
            hit_wall_reg <= div_out.wall;
        end

        // No hit: the whole remaining ray is consumed.
        if (state_reg == ST_DECIDE && !found_reg) begin
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= p_reg[k] + {{(PW-VW){r_reg[k][VW-1]}}, r_reg[k]};
            end
        end

        if (state_reg == ST_ADV && cnt_reg != 3'd0) begin
            p_reg[wb_axis] <= p_reg[wb_axis] + {{(PW-VW){prod_sh32[VW-1]}}, prod_sh32};
            r_reg[wb_axis] <= r_reg[wb_axis] - prod_sh32;
        end

        if (state_reg == ST_SCALE && cnt_reg != 3'd0) begin
            if (wbc < CNT_AXES) begin
                r_reg[wb_axis] <= prod_sh16;
            end else begin
                v_reg[wb_axis] <= prod_sh16;
            end
        end

        if (state_reg == ST_FIN && out_free) begin
            m_new_pos_x        <= bwbr_pkg::sat_q16(p_reg[0]);
            m_new_pos_y        <= bwbr_pkg::sat_q16(p_reg[1]);
            m_new_vel_x        <= bwbr_pkg::sat_q16({{(PW-VW){v_reg[0][VW-1]}}, v_reg[0]});
            m_new_vel_y        <= bwbr_pkg::sat_q16({{(PW-VW){v_reg[1][VW-1]}}, v_reg[1]});
            m_bounce_limit_hit <= limit_reg;
            if (DIMENSIONS == 2) begin
                m_new_pos_z <= '0;
                m_new_vel_z <= '0;
            end else begin
                m_new_pos_z <= bwbr_pkg::sat_q16(p_reg[2]);
                m_new_vel_z <= bwbr_pkg::sat_q16({{(PW-VW){v_reg[2][VW-1]}}, v_reg[2]});
            end
        end
    end

    // The bounce count never passes the limit.
    `BWBR_ASSERT(a_bounce_bound, bounce_cnt_reg <= BCW'(MAX_BOUNCES), "bounce count over limit")
    // Divider results only come back while the search collects them.
    `BWBR_ASSERT(a_div_in_drain, div_out.live |-> state_reg == ST_DRAIN, "stray divider result")
    // The limit flag is raised only once all reflections are used.
    `BWBR_ASSERT(a_limit_at_max, limit_reg |-> bounce_cnt_reg == BCW'(MAX_BOUNCES), "early limit flag")
    // Reset leaves the block idle with no result pending.
    `BWBR_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid), "reset not idle")

endmodule

// ----- src/bwbr_div_cell.sv -----
// One restoring division step: one quotient bit per cell, registered.
// Depends on bwbr_pkg.
module bwbr_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  bwbr_pkg::bwbr_div_t cell_in,
    output bwbr_pkg::bwbr_div_t cell_out
);

    logic [bwbr_pkg::RW-1:0] rem2;
    logic [bwbr_pkg::RW-1:0] diff;
    logic                    ge;

    // The remainder stays below the divisor, so doubling it fits RW bits.
    always_comb begin
        rem2 = {cell_in.rem[bwbr_pkg::RW-2:0], 1'b0};
        ge   = rem2 >= {1'b0, cell_in.dvs};
        diff = rem2 - {1'b0, cell_in.dvs};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_out.live <= 1'b0;
        end else begin
            cell_out.live <= cell_in.live;
        end
        cell_out.hit  <= cell_in.hit;
        cell_out.wall <= cell_in.wall;
        cell_out.dvs  <= cell_in.dvs;
        cell_out.rem  <= ge ? diff : rem2;
        cell_out.quo  <= {cell_in.quo[bwbr_pkg::QW-2:0], ge};
    end

endmodule

// ----- src/bwbr_div_chain.sv -----
// Row of division cells; a wall test enters each cycle and its Q0.32 hit
// time leaves the last cell. Depends on bwbr_pkg and bwbr_div_cell.
module bwbr_div_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  bwbr_pkg::bwbr_div_t div_in,
    output bwbr_pkg::bwbr_div_t div_out
);

    bwbr_pkg::bwbr_div_t link [bwbr_pkg::QW+1];

    assign link[0] = div_in;

    for (genvar g = 0; g < bwbr_pkg::QW; g++) begin : g_cell
        bwbr_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (link[g]),
            .cell_out (link[g+1])
        );
    end

    assign div_out = link[bwbr_pkg::QW];

endmodule
